// ===== hw/rtl/ptob_pkg.sv =====
// Package with shared types and codes for the price-time order book core.
package ptob_pkg;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_REG   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_ADD    = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   localparam logic SIDE_BUY = 1'b0;

   // Broadcast command to every cell of one book.
   typedef struct packed {
      logic ins;
      logic del;
      logic side;
   } cell_cmd_type;

endpackage

// ===== hw/rtl/ptob_cell.sv =====
// One slot of a sorted book chain, holding one stored entry of every book.
module ptob_cell #(
   parameter int NUM_BOOKS  = 16,
   parameter int PRICE_BITS = 32,
   parameter int ID_BITS    = 32
) (
   input  logic                         clock,
   input  ptob_pkg::cell_cmd_type       cmd,
   input  logic [$clog2(NUM_BOOKS)-1:0] book,
   input  logic                         load_fill,
   input  logic [PRICE_BITS-1:0]        new_price,
   input  logic [ID_BITS-1:0]           new_id,
   input  logic                         occupied,
   input  logic                         prev_ahead,
   input  logic                         prev_match,
   input  logic [PRICE_BITS-1:0]        prev_price,
   input  logic [ID_BITS-1:0]           prev_id,
   input  logic [PRICE_BITS-1:0]        next_price,
   input  logic [ID_BITS-1:0]           next_id,
   output logic                         ahead,
   output logic                         match_seen,
   output logic [PRICE_BITS-1:0]        cur_price,
   output logic [ID_BITS-1:0]           cur_id
);
   import ptob_pkg::*;

   logic [PRICE_BITS-1:0] price_ff [NUM_BOOKS];
   logic [ID_BITS-1:0]    id_ff    [NUM_BOOKS];
   logic                  self_ahead;
   logic                  self_match;

   assign cur_price  = price_ff[book];
   assign cur_id     = id_ff[book];
   assign self_ahead = occupied &&
      ((cmd.side == SIDE_BUY) ? (cur_price >= new_price) : (cur_price <= new_price));
   assign ahead      = prev_ahead && self_ahead;
   assign self_match = occupied && (cur_price == new_price) && (cur_id == new_id);
   assign match_seen = prev_match || self_match;

   always_ff @(posedge clock) begin
      if (cmd.ins && !load_fill && !ahead) begin
         if (prev_ahead) begin
            price_ff[book] <= new_price;
            id_ff[book]    <= new_id;
         end else begin
            price_ff[book] <= prev_price;
            id_ff[book]    <= prev_id;
         end
      end else if (cmd.del && match_seen) begin
         price_ff[book] <= next_price;
         id_ff[book]    <= next_id;
      end
   end

endmodule

// ===== hw/rtl/ptob_chain.sv =====
// Row of book cells with the neighbor links and the per-book fill counts.
module ptob_chain #(
   parameter int NUM_BOOKS  = 16,
   parameter int BOOK_DEPTH = 64,
   parameter int PRICE_BITS = 32,
   parameter int ID_BITS    = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ptob_pkg::cell_cmd_type         cmd,
   input  logic [$clog2(NUM_BOOKS)-1:0]   book,
   input  logic [PRICE_BITS-1:0]          new_price,
   input  logic [ID_BITS-1:0]             new_id,
   output logic                           full,
   output logic                           found,
   output logic                           head_valid,
   output logic [PRICE_BITS-1:0]          head_price,
   output logic [ID_BITS-1:0]             head_id
);
   import ptob_pkg::*;

   localparam int FILL_BITS = $clog2(BOOK_DEPTH + 1);

   logic [FILL_BITS-1:0]  fill_ff [NUM_BOOKS];
   logic [FILL_BITS-1:0]  fill;
   logic [BOOK_DEPTH:0]   ahead;
   logic [BOOK_DEPTH:0]   match;
   logic [PRICE_BITS-1:0] price [BOOK_DEPTH+1];
   logic [ID_BITS-1:0]    id    [BOOK_DEPTH+1];
   logic [PRICE_BITS-1:0] head_price_raw;
   logic [ID_BITS-1:0]    head_id_raw;

   assign fill     = fill_ff[book];
   assign full     = (fill == FILL_BITS'(BOOK_DEPTH));
   assign found    = match[BOOK_DEPTH];
   assign ahead[0] = 1'b1;
   assign match[0] = 1'b0;
   assign price[BOOK_DEPTH] = '0;
   assign id[BOOK_DEPTH]    = '0;

   for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
      logic [PRICE_BITS-1:0] pp;
      logic [ID_BITS-1:0]    pi;
      if (i == 0) begin : g_first
         assign pp = new_price;
         assign pi = new_id;
      end else begin : g_rest
         assign pp = price[i-1];
         assign pi = id[i-1];
      end
      ptob_cell #(
         .NUM_BOOKS(NUM_BOOKS), .PRICE_BITS(PRICE_BITS), .ID_BITS(ID_BITS)
      ) u_cell (
         .clock(clock), .cmd(cmd), .book(book), .load_fill(full),
         .new_price(new_price), .new_id(new_id),
         .occupied(FILL_BITS'(i) < fill),
         .prev_ahead(ahead[i]), .prev_match(match[i]),
         .prev_price(pp), .prev_id(pi),
         .next_price(price[i+1]), .next_id(id[i+1]),
         .ahead(ahead[i+1]), .match_seen(match[i+1]),
         .cur_price(price[i]), .cur_id(id[i])
      );
   end

   // Head entry of the addressed book as it stands after this cycle's command.
   assign head_valid     = (cmd.ins && !full) ? 1'b1 :
                           (cmd.del && found) ? (fill != FILL_BITS'(1)) : (fill != '0);
   assign head_price_raw = (cmd.ins && !full && !ahead[1]) ? new_price :
                           (cmd.del && match[1]) ? price[1] : price[0];
   assign head_id_raw    = (cmd.ins && !full && !ahead[1]) ? new_id :
                           (cmd.del && match[1]) ? id[1] : id[0];
   assign head_price     = head_valid ? head_price_raw : '0;
   assign head_id        = head_valid ? head_id_raw : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BOOKS; b++) fill_ff[b] <= '0;
      end else if (cmd.ins && !full) begin
         fill_ff[book] <= fill + FILL_BITS'(1);
      end else if (cmd.del && found) begin
         fill_ff[book] <= fill - FILL_BITS'(1);
      end
   end

endmodule

// ===== hw/rtl/price_time_order_book_core.sv =====
// Top level of the price-time order book core with command sequencing.
//
// An item is accepted at a rising edge where start is high and busy is low,
// and then passes through states ST_IDLE and ST_READ. In ST_IDLE the addressed
// book's cell chain compares and shifts in one step (insert or delete) and the
// new head entry of that book is captured. In ST_READ busy is high, no new item
// is taken, and the head entry of the instrument's other book is read from the
// first cell. The result is then strobed on rsp_valid for the one cycle that
// follows, so the next item can be started while it is shown and its transfer
// overlaps the previous result. Results cannot be stalled.
module price_time_order_book_core #(
   parameter int NUM_INSTRUMENTS = 8,
   parameter int BOOK_DEPTH      = 64,
   parameter int PRICE_BITS      = 32,
   parameter int ID_BITS         = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [7:0]  csr_instrument_enable,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [2:0]  req_instrument_index,
   input  logic        req_side,
   input  logic [31:0] req_price,
   input  logic [31:0] req_order_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_best_bid_valid,
   output logic [31:0] rsp_best_bid_id,
   output logic [31:0] rsp_best_bid_price,
   output logic        rsp_best_ask_valid,
   output logic [31:0] rsp_best_ask_id,
   output logic [31:0] rsp_best_ask_price
);
   import ptob_pkg::*;

   localparam int NUM_BOOKS = 2 * NUM_INSTRUMENTS;
   localparam int BK_BITS   = $clog2(NUM_BOOKS);
   localparam int PW        = (PRICE_BITS < 32) ? PRICE_BITS : 32;
   localparam int IW        = (ID_BITS < 32) ? ID_BITS : 32;

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type             state_ff;
   logic [7:0]            enable_ff;
   logic [1:0]            status_ff;
   logic                  reg_ff;
   logic [BK_BITS-1:0]    book_ff;
   logic                  head_valid_ff;
   logic [PRICE_BITS-1:0] head_price_ff;
   logic [ID_BITS-1:0]    head_id_ff;
   logic                  accept;
   logic                  registered;
   logic [BK_BITS-1:0]    book;
   logic [BK_BITS-1:0]    other_book;
   logic [BK_BITS-1:0]    chain_book;
   cell_cmd_type          cmd;
   logic [PRICE_BITS-1:0] new_price;
   logic [ID_BITS-1:0]    new_id;
   logic                  full;
   logic                  found;
   logic                  head_valid;
   logic [PRICE_BITS-1:0] head_price;
   logic [ID_BITS-1:0]    head_id;
   logic                  valid_a;
   logic                  valid_b;
   logic [PRICE_BITS-1:0] price_a;
   logic [PRICE_BITS-1:0] price_b;
   logic [ID_BITS-1:0]    id_a;
   logic [ID_BITS-1:0]    id_b;
   logic [1:0]            status_in;

   assign busy       = (state_ff == ST_READ);
   assign accept     = start && !busy;
   assign registered = (32'(req_instrument_index) < 32'(NUM_INSTRUMENTS)) &&
                       enable_ff[req_instrument_index];
   assign book       = BK_BITS'({req_instrument_index, req_side});
   assign other_book = book_ff ^ BK_BITS'(1);
   assign chain_book = busy ? other_book : book;
   assign new_price  = PRICE_BITS'(req_price);
   assign new_id     = ID_BITS'(req_order_id);
   assign cmd        = '{ins:  accept && registered && (req_func == FUNC_ADD),
                         del:  accept && registered && (req_func == FUNC_REMOVE),
                         side: req_side};

   ptob_chain #(
      .NUM_BOOKS(NUM_BOOKS), .BOOK_DEPTH(BOOK_DEPTH),
      .PRICE_BITS(PRICE_BITS), .ID_BITS(ID_BITS)
   ) u_chain (
      .clock(clock), .reset(reset), .cmd(cmd), .book(chain_book),
      .new_price(new_price), .new_id(new_id), .full(full), .found(found),
      .head_valid(head_valid), .head_price(head_price), .head_id(head_id)
   );

   always_comb begin
      if (book_ff[0] == SIDE_BUY) begin
         valid_a = head_valid_ff;
         price_a = head_price_ff;
         id_a    = head_id_ff;
         valid_b = head_valid;
         price_b = head_price;
         id_b    = head_id;
      end else begin
         valid_a = head_valid;
         price_a = head_price;
         id_a    = head_id;
         valid_b = head_valid_ff;
         price_b = head_price_ff;
         id_b    = head_id_ff;
      end
   end

   always_comb begin
      if (!registered)             status_in = STATUS_NOT_REG;
      else if (cmd.ins && full)    status_in = STATUS_FULL;
      else if (cmd.del && !found)  status_in = STATUS_NOT_FOUND;
      else                         status_in = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         enable_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_write) enable_ff <= csr_instrument_enable;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff      <= ST_READ;
                  status_ff     <= status_in;
                  reg_ff        <= registered;
                  book_ff       <= book;
                  head_valid_ff <= head_valid;
                  head_price_ff <= head_price;
                  head_id_ff    <= head_id;
               end
            end
            ST_READ: begin
               state_ff           <= ST_IDLE;
               rsp_valid          <= 1'b1;
               rsp_status         <= status_ff;
               rsp_best_bid_valid <= reg_ff && valid_a;
               rsp_best_bid_price <= reg_ff ? 32'(price_a[PW-1:0]) : '0;
               rsp_best_bid_id    <= reg_ff ? 32'(id_a[IW-1:0]) : '0;
               rsp_best_ask_valid <= reg_ff && valid_b;
               rsp_best_ask_price <= reg_ff ? 32'(price_b[PW-1:0]) : '0;
               rsp_best_ask_id    <= reg_ff ? 32'(id_b[IW-1:0]) : '0;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
